FILE: design/epid_pkg.sv
// Shared types, constants and the microcode table of the encoder PID PWM channel.
package epid_pkg;

    // Sequencer geometry
    localparam int StepW = 4;

    // Configuration port geometry
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 23;

    // Datapath widths: 17-bit unsigned-as-signed A times 25-bit signed B
    localparam int MulAW = 16;
    localparam int MulBW = 25;
    localparam int ProdW = MulAW + 1 + MulBW;

    // Register indexes of the configuration port
    typedef enum logic [CfgIdxW-1:0] {
        CFG_PROP_GAIN      = 3'd0,
        CFG_INTEG_GAIN     = 3'd1,
        CFG_DERIV_GAIN     = 3'd2,
        CFG_INTEGRAL_LIMIT = 3'd3,
        CFG_OUTPUT_LIMIT   = 3'd4,
        CFG_REVERSE_ERROR  = 3'd5,
        CFG_PWM_PERIOD     = 3'd6,
        CFG_SPEED_SCALE    = 3'd7
    } t_cfg_idx;

    // Configuration register file
    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] integ_gain;
        logic [15:0] deriv_gain;
        logic [22:0] integral_limit;
        logic [8:0]  output_limit;
        logic        reverse_error;
        logic [15:0] pwm_period;
        logic [15:0] speed_scale;
    } t_cfg;

    localparam t_cfg CfgReset = '{
        prop_gain:      16'd0,
        integ_gain:     16'd0,
        deriv_gain:     16'd0,
        integral_limit: 23'd2560,
        output_limit:   9'd256,
        reverse_error:  1'b0,
        pwm_period:     16'd0,
        speed_scale:    16'd0
    };

    // Multiplier operand selects
    typedef enum logic [2:0] {
        A_SCALE,
        A_PGAIN,
        A_IGAIN,
        A_DGAIN,
        A_PERIOD
    } t_a_sel;

    typedef enum logic [2:0] {
        B_DELTA,
        B_ERR,
        B_ESUM,
        B_DIFF,
        B_MAG
    } t_b_sel;

    // Accumulator operation
    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    // Jump conditions
    typedef enum logic [1:0] {
        J_NONE,
        J_NO_IN,
        J_OUT_FULL
    } t_jmp;

    // One control word of the program
    typedef struct packed {
        t_a_sel           a_sel;
        t_b_sel           b_sel;
        logic             mul_en;
        t_acc_op          acc_op;
        logic             ld_err;
        logic             ld_esum;
        logic             ld_drive;
        logic             in_take;
        logic             out_put;
        t_jmp             jmp;
        logic [StepW-1:0] target;
        logic             wrap;
    } t_ctrl;

    // Status fed back to the sequencer
    typedef struct packed {
        logic in_valid;
        logic out_full;
    } t_stat;

    // Program store
    function automatic t_ctrl ucode(input logic [StepW-1:0] step);
        t_ctrl c;
        c = '0;
        case (step)
            4'd0: begin                     // wait for an input word
                c.in_take = 1'b1;
                c.jmp     = J_NO_IN;
                c.target  = 4'd0;
            end
            4'd1: begin                     // delta * scale
                c.a_sel  = A_SCALE;
                c.b_sel  = B_DELTA;
                c.mul_en = 1'b1;
            end
            4'd2: begin                     // speed and error
                c.ld_err = 1'b1;
            end
            4'd3: begin                     // integrate, difference, P product
                c.ld_esum = 1'b1;
                c.a_sel   = A_PGAIN;
                c.b_sel   = B_ERR;
                c.mul_en  = 1'b1;
            end
            4'd4: begin                     // acc = P, I product
                c.acc_op = ACC_LOAD;
                c.a_sel  = A_IGAIN;
                c.b_sel  = B_ESUM;
                c.mul_en = 1'b1;
            end
            4'd5: begin                     // acc += I, D product
                c.acc_op = ACC_ADD;
                c.a_sel  = A_DGAIN;
                c.b_sel  = B_DIFF;
                c.mul_en = 1'b1;
            end
            4'd6: begin                     // acc += D
                c.acc_op = ACC_ADD;
            end
            4'd7: begin                     // scale down and clamp drive
                c.ld_drive = 1'b1;
            end
            4'd8: begin                     // period * duty magnitude
                c.a_sel  = A_PERIOD;
                c.b_sel  = B_MAG;
                c.mul_en = 1'b1;
            end
            4'd9: begin                     // hand result to the output register
                c.out_put = 1'b1;
                c.jmp     = J_OUT_FULL;
                c.target  = 4'd9;
                c.wrap    = 1'b1;
            end
            default: begin
                c.wrap = 1'b1;
            end
        endcase
        return c;
    endfunction

endpackage

FILE: design/epid_chan_if.sv
// Valid/ready channel interfaces for the input and result words.
interface epid_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] encoder_delta;
    logic signed [15:0] target_speed;

    modport source (output valid, output encoder_delta, output target_speed, input ready);
    modport sink   (input valid, input encoder_delta, input target_speed, output ready);
endinterface

interface epid_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] measured_speed;
    logic signed [9:0]  drive;
    logic [15:0]        compare_value;
    logic               direction;

    modport source (output valid, output measured_speed, output drive,
                    output compare_value, output direction, input ready);
    modport sink   (input valid, input measured_speed, input drive,
                    input compare_value, input direction, output ready);
endinterface

FILE: design/epid_seq.sv
// Microcode sequencer: step counter, program store and conditional jumps.
module epid_seq
    import epid_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    logic [StepW-1:0] r_step;
    logic [StepW-1:0] n_step;
    logic             jump_taken;

    assign o_ctrl = ucode(r_step);

    // jump condition
    always_comb begin
        case (o_ctrl.jmp)
            J_NO_IN:    jump_taken = !i_stat.in_valid;
            J_OUT_FULL: jump_taken = i_stat.out_full;
            default:    jump_taken = 1'b0;
        endcase
    end

    // next step
    always_comb begin
        if (jump_taken) begin
            n_step = o_ctrl.target;
        end else if (o_ctrl.wrap) begin
            n_step = '0;
        end else begin
            n_step = r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

FILE: design/epid_dp.sv
// Datapath: shared multiplier, accumulator, speed, error and drive registers.
module epid_dp
    import epid_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_ctrl              i_ctrl,
    input  t_cfg               i_cfg,
    input  logic               i_in_valid,
    input  logic signed [15:0] i_encoder_delta,
    input  logic signed [15:0] i_target_speed,
    output logic signed [15:0] o_speed,
    output logic signed [9:0]  o_drive,
    output logic [15:0]        o_compare
);

    logic signed [15:0]      r_delta;
    logic signed [15:0]      r_target;
    logic signed [15:0]      r_speed;
    logic signed [15:0]      r_err;
    logic signed [15:0]      r_last;
    logic signed [23:0]      r_esum;
    logic signed [16:0]      r_diff;
    logic signed [9:0]       r_drive;
    logic signed [ProdW-1:0] r_prod;
    logic signed [ProdW-1:0] r_acc;

    logic [MulAW-1:0]        mul_a;
    logic signed [MulBW-1:0] mul_b;
    logic signed [ProdW-1:0] prod_c;
    logic [9:0]              mag_sum;
    logic [8:0]              mag;

    logic signed [33:0]      sp_sh;
    logic signed [15:0]      speed_c;
    logic signed [16:0]      err_raw;
    logic signed [15:0]      err_c;
    logic signed [24:0]      esum_raw;
    logic signed [24:0]      ilim;
    logic signed [23:0]      esum_c;
    logic signed [29:0]      d_sh;
    logic [8:0]              olim9;
    logic signed [29:0]      olim;
    logic signed [9:0]       drive_c;

    // multiplier operands
    always_comb begin
        case (i_ctrl.a_sel)
            A_SCALE:  mul_a = i_cfg.speed_scale;
            A_PGAIN:  mul_a = i_cfg.prop_gain;
            A_IGAIN:  mul_a = i_cfg.integ_gain;
            A_DGAIN:  mul_a = i_cfg.deriv_gain;
            A_PERIOD: mul_a = i_cfg.pwm_period;
            default:  mul_a = '0;
        endcase
    end

    // duty magnitude: drive, or full scale plus drive when negative
    assign mag_sum = 10'd256 + r_drive;
    assign mag     = r_drive[9] ? mag_sum[8:0] : r_drive[8:0];

    always_comb begin
        case (i_ctrl.b_sel)
            B_DELTA: mul_b = {{(MulBW-16){r_delta[15]}}, r_delta};
            B_ERR:   mul_b = {{(MulBW-16){r_err[15]}}, r_err};
            B_ESUM:  mul_b = {{(MulBW-24){r_esum[23]}}, r_esum};
            B_DIFF:  mul_b = {{(MulBW-17){r_diff[16]}}, r_diff};
            B_MAG:   mul_b = {{(MulBW-9){1'b0}}, mag};
            default: mul_b = '0;
        endcase
    end

    assign prod_c = $signed({1'b0, mul_a}) * mul_b;

    // speed: floor(product / 256), saturated symmetric
    assign sp_sh = $signed(r_prod[41:8]);
    always_comb begin
        if (sp_sh > 34'sd32767) begin
            speed_c = 16'sd32767;
        end else if (sp_sh < -34'sd32767) begin
            speed_c = -16'sd32767;
        end else begin
            speed_c = sp_sh[15:0];
        end
    end

    // error with optional reversal, saturated to 16 bits
    always_comb begin
        if (i_cfg.reverse_error) begin
            err_raw = {speed_c[15], speed_c} - {r_target[15], r_target};
        end else begin
            err_raw = {r_target[15], r_target} - {speed_c[15], speed_c};
        end
        if (err_raw > 17'sd32767) begin
            err_c = 16'sd32767;
        end else if (err_raw < -17'sd32768) begin
            err_c = -16'sd32768;
        end else begin
            err_c = err_raw[15:0];
        end
    end

    // integral with symmetric clamp
    assign esum_raw = {r_esum[23], r_esum} + {{9{r_err[15]}}, r_err};
    assign ilim     = $signed({2'b00, i_cfg.integral_limit});
    always_comb begin
        if (esum_raw > ilim) begin
            esum_c = ilim[23:0];
        end else if (esum_raw < -ilim) begin
            esum_c = -ilim[23:0];
        end else begin
            esum_c = esum_raw[23:0];
        end
    end

    // drive: floor(acc / 4096) clamped to the output limit, never past full duty
    assign d_sh  = $signed(r_acc[41:12]);
    assign olim9 = (i_cfg.output_limit > 9'd256) ? 9'd256 : i_cfg.output_limit;
    assign olim  = $signed({21'd0, olim9});
    always_comb begin
        if (d_sh > olim) begin
            drive_c = olim[9:0];
        end else if (d_sh < -olim) begin
            drive_c = -olim[9:0];
        end else begin
            drive_c = d_sh[9:0];
        end
    end

    // controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esum <= '0;
            r_last <= '0;
        end else if (i_ctrl.ld_esum) begin
            r_esum <= esum_c;
            r_last <= r_err;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_ctrl.in_take && i_in_valid) begin
            r_delta  <= i_encoder_delta;
            r_target <= i_target_speed;
        end
        if (i_ctrl.mul_en) begin
            r_prod <= prod_c;
        end
        if (i_ctrl.ld_err) begin
            r_speed <= speed_c;
            r_err   <= err_c;
        end
        if (i_ctrl.ld_esum) begin
            r_diff <= {r_err[15], r_err} - {r_last[15], r_last};
        end
        if (i_ctrl.ld_drive) begin
            r_drive <= drive_c;
        end
        case (i_ctrl.acc_op)
            ACC_LOAD: r_acc <= r_prod;
            ACC_ADD:  r_acc <= r_acc + r_prod;
            default:  r_acc <= r_acc;
        endcase
    end

    assign o_speed   = r_speed;
    assign o_drive   = r_drive;
    assign o_compare = r_prod[23:8];

endmodule

FILE: design/encoder_pid_pwm_channel_core.sv
// Top level: configuration registers, channel handshakes and the result register.
//
// One PID speed loop per instance. Each input word (encoder delta, target speed) is
// turned into a measured Q8.8 speed, a clamped drive, a PWM compare value and a
// direction bit. A ten-step microcode program runs one shared 17x25 multiplier five
// times per word. The program waits for a word in its first step and loads the result
// into the output register in its last step; a new word is taken only once the last
// one is through. The next word is accepted right after a result is loaded, while
// that result still waits to be taken. If the previous result has not been taken,
// the program holds at its last step until it is. Configuration writes are taken at
// any time and are meant to be made only while no word is in progress.
module encoder_pid_pwm_channel_core
    import epid_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_wr_en,
    input  logic [CfgIdxW-1:0]  i_cfg_addr,
    input  logic [CfgDataW-1:0] i_cfg_wdata,
    epid_in_if.sink             i_in,
    epid_out_if.source          o_out
);

    t_cfg  r_cfg;
    t_ctrl ctrl;
    t_stat stat;

    logic               r_out_valid;
    logic signed [15:0] r_out_speed;
    logic signed [9:0]  r_out_drive;
    logic [15:0]        r_out_compare;
    logic               r_out_dir;

    logic signed [15:0] dp_speed;
    logic signed [9:0]  dp_drive;
    logic [15:0]        dp_compare;
    logic               out_full;
    logic               out_put;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CfgReset;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_PROP_GAIN:      r_cfg.prop_gain      <= i_cfg_wdata[15:0];
                CFG_INTEG_GAIN:     r_cfg.integ_gain     <= i_cfg_wdata[15:0];
                CFG_DERIV_GAIN:     r_cfg.deriv_gain     <= i_cfg_wdata[15:0];
                CFG_INTEGRAL_LIMIT: r_cfg.integral_limit <= i_cfg_wdata[22:0];
                CFG_OUTPUT_LIMIT:   r_cfg.output_limit   <= i_cfg_wdata[8:0];
                CFG_REVERSE_ERROR:  r_cfg.reverse_error  <= i_cfg_wdata[0];
                CFG_PWM_PERIOD:     r_cfg.pwm_period     <= i_cfg_wdata[15:0];
                CFG_SPEED_SCALE:    r_cfg.speed_scale    <= i_cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // handshake status
    assign out_full      = r_out_valid && !o_out.ready;
    assign out_put       = ctrl.out_put && !out_full;
    assign stat.in_valid = i_in.valid;
    assign stat.out_full = out_full;
    assign i_in.ready    = ctrl.in_take;

    epid_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    epid_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_cfg           (r_cfg),
        .i_in_valid      (i_in.valid),
        .i_encoder_delta (i_in.encoder_delta),
        .i_target_speed  (i_in.target_speed),
        .o_speed         (dp_speed),
        .o_drive         (dp_drive),
        .o_compare       (dp_compare)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_put) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_put) begin
            r_out_speed   <= dp_speed;
            r_out_drive   <= dp_drive;
            r_out_compare <= dp_compare;
            r_out_dir     <= dp_drive[9];
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.measured_speed = r_out_speed;
    assign o_out.drive          = r_out_drive;
    assign o_out.compare_value  = r_out_compare;
    assign o_out.direction      = r_out_dir;

    // direction always follows the sign of the drive
    a_dir_sign: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.direction == o_out.drive[9]))
        else $error("direction does not match drive sign");

    // drive never exceeds full duty
    a_drive_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.drive <= 10'sd256 && o_out.drive >= -10'sd256))
        else $error("drive beyond full duty");

    // zero drive gives a zero compare value
    a_zero_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.drive == 10'sd0) |-> (o_out.compare_value == 16'd0))
        else $error("nonzero compare for zero drive");

    // one word at a time: program leaves the wait step after an accept
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input accepted while a word is in progress");

endmodule
